[rtl/core/rgb_keyframe_interpolator_core_assert.svh]
// assertion macros for the keyframe interpolator core
`ifndef RGB_KEYFRAME_INTERPOLATOR_CORE_ASSERT_SVH
`define RGB_KEYFRAME_INTERPOLATOR_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RKI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define RKI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/rki_pkg.sv]
// shared types and constants of the keyframe interpolator core
package rki_pkg;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	localparam int CHANNELS = 3;
	localparam int QBITS    = 17;

	typedef logic [15:0] q16_t;
	typedef logic [3:0]  key_count_t;
	typedef logic [4:0]  cnt_t;

	localparam cnt_t DIV_LAST_STEP = cnt_t'(QBITS - 1);

	typedef struct packed {
		logic       mode;
		logic [2:0] key_index;
		q16_t       key_time;
		q16_t       key_red;
		q16_t       key_green;
		q16_t       key_blue;
		q16_t       query_percent;
	} rki_in_t;

	typedef struct packed {
		q16_t red_out;
		q16_t green_out;
		q16_t blue_out;
		logic span_fault;
	} rki_out_t;

	typedef struct packed {
		q16_t key_time;
		q16_t red;
		q16_t green;
		q16_t blue;
	} rki_entry_t;

	typedef struct packed {
		logic mem_we;
		logic rd_en;
		logic ld_query;
		logic save_s;
		logic save_e;
		logic calc;
		logic mul;
		logic div_init;
		logic div_step;
		logic load_out;
		logic out_blend;
		logic out_fault;
	} rki_cmd_t;

	typedef struct packed {
		logic t_gt;
		logic den_bad;
	} rki_stat_t;

endpackage

[rtl/core/rki_ctrl.sv]
// controller: table scan sequencing, divider steps and output register valid
module rki_ctrl import rki_pkg::*; #(
	parameter int MAX_KEYS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_mode,
	output logic                          in_ready,
	output logic                          out_valid,
	input  logic                          out_ready,
	input  key_count_t                    key_count,
	input  rki_stat_t                     stat,
	output rki_cmd_t                      cmd,
	output logic [$clog2(MAX_KEYS)-1:0]   rd_addr
);

	localparam int AW = $clog2(MAX_KEYS);
	localparam int CW = $clog2(MAX_KEYS + 1);
	localparam int KW = (CW > 4) ? CW : 4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CALC,
		ST_MUL,
		ST_DINIT,
		ST_DIV,
		ST_FIN,
		ST_PASS
	} state_t;

	state_t          state_q, state_d;
	logic [AW-1:0]   i_q;
	cnt_t            cnt_q;
	logic            out_valid_q;
	logic            fault_q;
	logic            out_free;
	logic [KW-1:0]   kc;
	logic [KW-1:0]   nk;
	logic [AW-1:0]   last_idx;

	// keys in use, clamped to 1..MAX_KEYS
	always_comb begin
		kc = KW'(key_count);
		if (kc == '0) begin
			nk = KW'(1);
		end else if (kc > KW'(MAX_KEYS)) begin
			nk = KW'(MAX_KEYS);
		end else begin
			nk = kc;
		end
		last_idx = AW'(nk - KW'(1));
	end

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		rd_addr = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_mode == MODE_WRITE) begin
						cmd.mem_we = 1'b1;
					end else begin
						cmd.ld_query = 1'b1;
						cmd.rd_en    = 1'b1;
						state_d      = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				// rd_q holds entry i_q
				if (i_q == '0) begin
					cmd.save_s = 1'b1;
					if (last_idx == '0) begin
						state_d = ST_PASS;
					end else begin
						cmd.rd_en = 1'b1;
						rd_addr   = i_q + 1'b1;
					end
				end else if (stat.t_gt) begin
					cmd.save_e = 1'b1;
					state_d    = ST_CALC;
				end else begin
					cmd.save_s = 1'b1;
					if (i_q == last_idx) begin
						state_d = ST_PASS;
					end else begin
						cmd.rd_en = 1'b1;
						rd_addr   = i_q + 1'b1;
					end
				end
			end
			ST_CALC: begin
				if (stat.den_bad) begin
					state_d = ST_PASS;
				end else begin
					cmd.calc = 1'b1;
					state_d  = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_DINIT;
			end
			ST_DINIT: begin
				cmd.div_init = 1'b1;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == '0) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.load_out  = 1'b1;
					cmd.out_blend = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_PASS: begin
				if (out_free) begin
					cmd.load_out  = 1'b1;
					cmd.out_fault = fault_q;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			i_q         <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			fault_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.rd_en) begin
				i_q <= rd_addr;
			end
			if (cmd.div_init) begin
				cnt_q <= DIV_LAST_STEP;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			// bad span comes from the calc state, running off the table does not
			if (state_d == ST_PASS && state_q != ST_PASS) begin
				fault_q <= (state_q == ST_CALC);
			end
		end
	end

endmodule

[rtl/core/rki_datapath.sv]
// datapath: keyframe table, span setup, three multiplier and divider lanes, output register
module rki_datapath import rki_pkg::*; #(
	parameter int MAX_KEYS = 8
) (
	input  logic                          clk,
	input  rki_in_t                       in_data,
	input  rki_cmd_t                      cmd,
	input  logic [$clog2(MAX_KEYS)-1:0]   rd_addr,
	output rki_stat_t                     stat,
	output rki_out_t                      out_data
);

	localparam int AW = $clog2(MAX_KEYS);

	rki_entry_t    mem [MAX_KEYS];
	rki_entry_t    wr_entry;
	logic [AW-1:0] wr_addr;
	logic          wr_ok;

	rki_entry_t    rd_q;
	rki_entry_t    s_q;
	rki_entry_t    e_q;
	q16_t          p_q;
	q16_t          num_mag_q;
	q16_t          den_q;
	logic [QBITS+15:0] dsh_q;

	q16_t          dmag_q [CHANNELS];
	logic          neg_q  [CHANNELS];
	logic [31:0]   m_q    [CHANNELS];
	logic [31:0]   rem_q  [CHANNELS];
	logic [QBITS-1:0] quo_q [CHANNELS];
	logic          ovf_q  [CHANNELS];
	rki_out_t      out_q;

	logic [16:0]   num;
	logic [16:0]   den;
	logic          num_neg;
	q16_t          num_mag;

	q16_t          cs   [CHANNELS];
	q16_t          ce   [CHANNELS];
	logic [16:0]   diff [CHANNELS];
	q16_t          blend [CHANNELS];
	logic          ge   [CHANNELS];

	// keyframe table
	assign wr_entry = '{key_time: in_data.key_time, red: in_data.key_red,
		green: in_data.key_green, blue: in_data.key_blue};
	assign wr_addr  = AW'(in_data.key_index);
	assign wr_ok    = 32'(in_data.key_index) < MAX_KEYS;

	always_ff @(posedge clk) begin
		if (cmd.mem_we && wr_ok) begin
			mem[wr_addr] <= wr_entry;
		end
		if (cmd.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign stat.t_gt = rd_q.key_time > p_q;

	// span setup
	always_comb begin
		num     = {1'b0, p_q} - {1'b0, s_q.key_time};
		den     = {1'b0, e_q.key_time} - {1'b0, s_q.key_time};
		num_neg = num[16];
		num_mag = num_neg ? 16'(-num) : num[15:0];
	end

	assign stat.den_bad = den[16] || (den == '0);

	assign cs[0] = s_q.red;
	assign cs[1] = s_q.green;
	assign cs[2] = s_q.blue;
	assign ce[0] = e_q.red;
	assign ce[1] = e_q.green;
	assign ce[2] = e_q.blue;

	always_comb begin
		for (int ch = 0; ch < CHANNELS; ch++) begin
			diff[ch] = {1'b0, ce[ch]} - {1'b0, cs[ch]};
			ge[ch]   = {1'b0, rem_q[ch]} >= dsh_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_query) begin
			p_q <= in_data.query_percent;
		end
		if (cmd.save_s) begin
			s_q <= rd_q;
		end
		if (cmd.save_e) begin
			e_q <= rd_q;
		end
		if (cmd.calc) begin
			num_mag_q <= num_mag;
			den_q     <= den[15:0];
		end
		if (cmd.div_init) begin
			dsh_q <= {1'b0, den_q, 16'b0};
		end else if (cmd.div_step) begin
			dsh_q <= dsh_q >> 1;
		end
		for (int ch = 0; ch < CHANNELS; ch++) begin
			if (cmd.calc) begin
				dmag_q[ch] <= diff[ch][16] ? 16'(-diff[ch]) : diff[ch][15:0];
				neg_q[ch]  <= diff[ch][16] ^ num_neg;
			end
			if (cmd.mul) begin
				m_q[ch] <= dmag_q[ch] * num_mag_q;
			end
			if (cmd.div_init) begin
				rem_q[ch] <= m_q[ch];
				quo_q[ch] <= '0;
				// quotient too wide for the lanes: saturates either way
				ovf_q[ch] <= {1'b0, m_q[ch]} >= {den_q, 17'b0};
			end else if (cmd.div_step) begin
				if (ge[ch]) begin
					rem_q[ch] <= rem_q[ch] - dsh_q[31:0];
				end
				quo_q[ch] <= {quo_q[ch][QBITS-2:0], ge[ch]};
			end
		end
	end

	// round half away from zero, apply sign, saturate
	always_comb begin
		logic          rnd;
		logic [17:0]   r;
		logic [18:0]   v;
		for (int ch = 0; ch < CHANNELS; ch++) begin
			rnd = {rem_q[ch][15:0], 1'b0} >= {1'b0, den_q};
			r   = {1'b0, quo_q[ch]} + 18'(rnd);
			if (neg_q[ch]) begin
				v = {3'b0, cs[ch]} - {1'b0, r};
			end else begin
				v = {3'b0, cs[ch]} + {1'b0, r};
			end
			if (ovf_q[ch]) begin
				blend[ch] = neg_q[ch] ? 16'h0000 : 16'hffff;
			end else if (v[18]) begin
				blend[ch] = 16'h0000;
			end else if (v[17:16] != 2'b00) begin
				blend[ch] = 16'hffff;
			end else begin
				blend[ch] = v[15:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			if (cmd.out_blend) begin
				out_q <= '{red_out: blend[0], green_out: blend[1], blue_out: blend[2],
					span_fault: 1'b0};
			end else begin
				out_q <= '{red_out: cs[0], green_out: cs[1], blue_out: cs[2],
					span_fault: cmd.out_fault};
			end
		end
	end

	assign out_data = out_q;

endmodule

[rtl/core/rgb_keyframe_interpolator_core.sv]
// keyframe colour interpolator top level: key count register, controller and datapath
// a write word gives no result
// a query scans k table entries at one per cycle, where k is at most the key count clamped
// to 1..MAX_KEYS; it then interpolates through the 17-step serial divider or passes the start entry on;
// the next word is taken once the result is queued
// reset clears control and sets key count to 1; the table holds nothing until written
`include "rgb_keyframe_interpolator_core_assert.svh"

module rgb_keyframe_interpolator_core import rki_pkg::*; #(
	parameter int MAX_KEYS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  rki_in_t    in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output rki_out_t   out_data,
	input  logic       cfg_we,
	input  key_count_t cfg_wdata
);

	localparam int AW = $clog2(MAX_KEYS);

	key_count_t    key_count_q;
	rki_cmd_t      cmd;
	rki_stat_t     stat;
	logic [AW-1:0] rd_addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q <= key_count_t'(1);
		end else if (cfg_we) begin
			key_count_q <= cfg_wdata;
		end
	end

	rki_ctrl #(
		.MAX_KEYS (MAX_KEYS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_mode   (in_data.mode),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.key_count (key_count_q),
		.stat      (stat),
		.cmd       (cmd),
		.rd_addr   (rd_addr)
	);

	rki_datapath #(
		.MAX_KEYS (MAX_KEYS)
	) u_datapath (
		.clk      (clk),
		.in_data  (in_data),
		.cmd      (cmd),
		.rd_addr  (rd_addr),
		.stat     (stat),
		.out_data (out_data)
	);

	// a new result never overwrites one still waiting
	`RKI_ASSERT_NOW(a_load_free, clk, arst_n, cmd.load_out, (!out_valid || out_ready), "result overwritten")
	// an accepted query keeps the input side closed
	`RKI_ASSERT_NEXT(a_query_busy, clk, arst_n, (in_valid && in_ready && in_data.mode == MODE_QUERY), !in_ready, "input open during query")
	// the divider only runs while the input side is closed
	`RKI_ASSERT_NOW(a_div_busy, clk, arst_n, cmd.div_step, !in_ready, "divider step while idle")
	// the table is written only from an accepted write word
	`RKI_ASSERT_NOW(a_write_src, clk, arst_n, cmd.mem_we, (in_valid && in_ready && in_data.mode == MODE_WRITE), "table write without write word")

endmodule
